// ===== sv/bmh_pkg.sv =====
// shared constants, codes and types for the binary min-heap priority queue
`timescale 1ns / 1ps

package bmh_pkg;

   localparam int HEAP_DEPTH_DEFAULT = 64;
   localparam int KEY_WIDTH_DEFAULT  = 32;
   localparam int DATA_WIDTH         = 32;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_POP    = 1'b1;

   typedef struct packed {
      logic ins;
      logic pop;
   } cell_ctrl_type;

endpackage

// ===== sv/bmh_cell.sv =====
// one cell of the sorted key chain: holds one key, takes from its neighbours
`timescale 1ns / 1ps

module bmh_cell #(
   parameter int KEY_WIDTH = bmh_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  bmh_pkg::cell_ctrl_type      ctrl,
   input  logic                        occupied,
   input  logic signed [KEY_WIDTH-1:0] new_key,
   input  logic signed [KEY_WIDTH-1:0] prev_key,
   input  logic                        prev_le,
   input  logic signed [KEY_WIDTH-1:0] next_key,
   output logic signed [KEY_WIDTH-1:0] key,
   output logic                        le
);

   logic signed [KEY_WIDTH-1:0] key_ff;
   logic signed [KEY_WIDTH-1:0] key_in;

   // own key stays ahead of the new key on a tie
   assign le  = occupied && (key_ff <= new_key);
   assign key = key_ff;

   always_comb begin
      key_in = key_ff;
      if (ctrl.ins) begin
         if (le) begin
            key_in = key_ff;
         end else if (prev_le) begin
            key_in = new_key;
         end else begin
            key_in = prev_key;
         end
      end else if (ctrl.pop) begin
         key_in = next_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

// ===== sv/binary_min_heap.sv =====
// binary_min_heap: sorted chain of key cells, smallest key in the first cell
// response: registered, appears in the cycle after the request is accepted
// throughput: one request per cycle while rsp_tready is high; every insert or pop updates all cells at once
// a new request is taken while the previous response is being taken
// reset: synchronous, active high; clears the entry count and response valid
// key cells are not reset and are only read below the entry count
`timescale 1ns / 1ps

module binary_min_heap #(
   parameter int HEAP_DEPTH = bmh_pkg::HEAP_DEPTH_DEFAULT,
   parameter int KEY_WIDTH  = bmh_pkg::KEY_WIDTH_DEFAULT,
   localparam int CountWidth = $clog2(HEAP_DEPTH + 1),
   localparam int RspWidth   = ((2 * bmh_pkg::DATA_WIDTH + CountWidth + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bmh_pkg::DATA_WIDTH-1:0]   req_tdata,  // value
   input  logic                             req_tuser,  // mode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [RspWidth-1:0]              rsp_tdata,  // popped_value, current_min, entry_count
   output logic [1:0]                       rsp_tuser   // popped_valid, rejected
);

   localparam int DW = bmh_pkg::DATA_WIDTH;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [CountWidth-1:0]       count_ff, count_in;
   logic [DW-1:0]               popped_value_ff, popped_value_in;
   logic                        popped_valid_ff, popped_valid_in;
   logic                        rejected_ff, rejected_in;

   logic                        accept;
   logic                        is_full;
   logic                        is_empty;
   logic signed [63:0]          value_ext;
   logic signed [KEY_WIDTH-1:0] new_key;
   logic signed [63:0]          min_ext;
   logic [DW-1:0]               current_min;
   bmh_pkg::cell_ctrl_type      ctrl;

   logic signed [KEY_WIDTH-1:0] cell_key [HEAP_DEPTH];
   logic [HEAP_DEPTH-1:0]       cell_le;
   logic [HEAP_DEPTH-1:0]       cell_occupied;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_full    = (count_ff == CountWidth'(HEAP_DEPTH));
   assign is_empty   = (count_ff == '0);

   assign value_ext = 64'(signed'(req_tdata));
   assign new_key   = value_ext[KEY_WIDTH-1:0];

   assign ctrl.ins = accept && (req_tuser == bmh_pkg::MODE_INSERT) && !is_full;
   assign ctrl.pop = accept && (req_tuser == bmh_pkg::MODE_POP) && !is_empty;

   genvar gi;
   generate
      for (gi = 0; gi < HEAP_DEPTH; gi++) begin : g_cell
         logic signed [KEY_WIDTH-1:0] prev_key;
         logic                        prev_le;
         logic signed [KEY_WIDTH-1:0] next_key;

         assign cell_occupied[gi] = (CountWidth'(gi) < count_ff);

         if (gi == 0) begin : g_first
            assign prev_key = new_key;
            assign prev_le  = 1'b1;
         end else begin : g_inner
            assign prev_key = cell_key[gi-1];
            assign prev_le  = cell_le[gi-1];
         end

         if (gi == HEAP_DEPTH - 1) begin : g_last
            assign next_key = new_key;
         end else begin : g_body
            assign next_key = cell_key[gi+1];
         end

         bmh_cell #(
            .KEY_WIDTH (KEY_WIDTH)
         ) u_cell (
            .clock    (clock),
            .ctrl     (ctrl),
            .occupied (cell_occupied[gi]),
            .new_key  (new_key),
            .prev_key (prev_key),
            .prev_le  (prev_le),
            .next_key (next_key),
            .key      (cell_key[gi]),
            .le       (cell_le[gi])
         );
      end
   endgenerate

   assign min_ext     = 64'(cell_key[0]);
   assign current_min = is_empty ? '0 : min_ext[DW-1:0];

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      count_in        = count_ff;
      popped_value_in = popped_value_ff;
      popped_valid_in = popped_valid_ff;
      rejected_in     = rejected_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in    = 1'b1;
         popped_value_in = '0;
         popped_valid_in = 1'b0;
         rejected_in     = 1'b0;
         if (req_tuser == bmh_pkg::MODE_INSERT) begin
            if (is_full) begin
               rejected_in = 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (is_empty) begin
               rejected_in = 1'b1;
            end else begin
               count_in        = count_ff - 1'b1;
               popped_value_in = min_ext[DW-1:0];
               popped_valid_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      popped_value_ff <= popped_value_in;
      popped_valid_ff <= popped_valid_in;
      rejected_ff     <= rejected_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspWidth'({count_ff, current_min, popped_value_ff});
   assign rsp_tuser  = {rejected_ff, popped_valid_ff};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(HEAP_DEPTH))
      else $error("entry count above heap depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.ins |=> count_ff == $past(count_ff) + 1'b1)
      else $error("accepted insert did not add an entry");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |=> count_ff == $past(count_ff) - 1'b1)
      else $error("accepted pop did not remove an entry");

   a_chain_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CountWidth'(2) |-> cell_key[0] <= cell_key[1])
      else $error("first two cells out of order");

   a_reject_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rejected_ff |-> !popped_valid_ff)
      else $error("rejected response also reports a pop");
`endif

endmodule
